// ===== sv/ntr_pkg.sv =====
// ----------------------------------------------------------------------------
// ntr_pkg
// Shared constants, types and sequencer states of the tone record converter.
// ----------------------------------------------------------------------------
package ntr_pkg;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned MAX_CHUNKS  = 63;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SHIFT_W     = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  // 63 * 253 fits in 14 bits
  localparam int unsigned LIM_W       = 14;

  localparam logic [BYTE_W-1:0]    REST_CODE   = 8'hFE;
  localparam logic [BYTE_W-1:0]    END_CODE    = 8'h00;
  localparam logic [BYTE_W-1:0]    END_LENGTH  = 8'hFF;
  localparam logic [BYTE_W-1:0]    CHUNK_RESET = 8'd248;
  localparam logic [BYTE_W-1:0]    CHUNK_TOP   = 8'd253;
  localparam logic [SHIFT_W-1:0]   SHIFT_RESET = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SHIFT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SCALE,
    ST_CLIP,
    ST_EMIT,
    ST_TERM
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  chunk;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tone_code;
    logic [BYTE_W-1:0] tone_length;
    logic              last_record;
    logic              clipped;
  } rec_t;

endpackage

// ===== sv/ntr_if.sv =====
// ----------------------------------------------------------------------------
// ntr_evt_if / ntr_rec_if
// Valid/ready channels for note events in and tone records out.
// ----------------------------------------------------------------------------
interface ntr_evt_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [ntr_pkg::TIME_BITS-1:0]       event_time;
  logic                                is_note_on;
  logic [ntr_pkg::NOTE_W-1:0]          note_number;

  modport source (output valid, cmd, event_time, is_note_on, note_number, input ready);
  modport sink   (input valid, cmd, event_time, is_note_on, note_number, output ready);
endinterface

interface ntr_rec_if;
  logic                         valid;
  logic                         ready;
  logic [ntr_pkg::BYTE_W-1:0]   tone_code;
  logic [ntr_pkg::BYTE_W-1:0]   tone_length;
  logic                         last_record;
  logic                         clipped;

  modport source (output valid, tone_code, tone_length, last_record, clipped, input ready);
  modport sink   (input valid, tone_code, tone_length, last_record, clipped, output ready);
endinterface

// ===== sv/ntr_sub.sv =====
// ----------------------------------------------------------------------------
// ntr_sub
// Shared subtractor: difference and borrow, used for gaps, clip test and
// chunk peeling.
// ----------------------------------------------------------------------------
module ntr_sub (
  input  logic [ntr_pkg::TIME_BITS-1:0] a_i,
  input  logic [ntr_pkg::TIME_BITS-1:0] b_i,
  output logic [ntr_pkg::TIME_BITS-1:0] diff_o,
  output logic                          borrow_o
);

  logic [ntr_pkg::TIME_BITS:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[ntr_pkg::TIME_BITS-1:0];
  assign borrow_o = full[ntr_pkg::TIME_BITS];

endmodule

// ===== sv/ntr_cfg.sv =====
// ----------------------------------------------------------------------------
// ntr_cfg
// Configuration registers; chunk limit is clamped to 1..253 on the way out.
// ----------------------------------------------------------------------------
module ntr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ntr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ntr_pkg::BYTE_W-1:0]    cfg_data_i,
  output ntr_pkg::cfg_t                 cfg_o
);

  logic [ntr_pkg::BYTE_W-1:0]  chunk_q;
  logic [ntr_pkg::SHIFT_W-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ntr_pkg::CHUNK_RESET;
      shift_q <= ntr_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ntr_pkg::CFG_MAX_CHUNK:  chunk_q <= cfg_data_i;
        ntr_pkg::CFG_TIME_SHIFT: shift_q <= cfg_data_i[ntr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.shift = shift_q;
    if (chunk_q == '0) begin
      cfg_o.chunk = 8'd1;
    end else if (chunk_q > ntr_pkg::CHUNK_TOP) begin
      cfg_o.chunk = ntr_pkg::CHUNK_TOP;
    end else begin
      cfg_o.chunk = chunk_q;
    end
  end

endmodule

// ===== sv/note_event_to_tone_records.sv =====
// ----------------------------------------------------------------------------
// note_event_to_tone_records
// Chord-merging note event to tone record converter with a shared
// subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  evt      in   evt.valid/evt.ready   cmd, event_time, is_note_on, note_number
//  rec      out  rec.valid/rec.ready   tone_code, tone_length, last_record, clipped
//  cfg      in   cfg_we_i              cfg_idx_i, cfg_data_i
//
//  An event that only merges or becomes held never leaves ST_IDLE. A release
//  passes ST_IDLE (accept), ST_DIFF (gap), ST_SCALE, ST_CLIP (clip test), then
//  ST_EMIT, one record per chunk and one pass more when the duration is zero or
//  ends on a full chunk; ST_TERM adds the terminator at end of stream. The shared
//  subtractor sets this order. Records leave through one output register; a stall
//  on rec holds the sequencer. No clearing pass after reset.
// ----------------------------------------------------------------------------
module note_event_to_tone_records (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ntr_evt_if.sink                       evt,
  ntr_rec_if.source                     rec,
  input  logic                          cfg_we_i,
  input  logic [ntr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ntr_pkg::BYTE_W-1:0]    cfg_data_i
);

  localparam int unsigned TW = ntr_pkg::TIME_BITS;

  ntr_pkg::cfg_t   cfg;
  ntr_pkg::state_e state_q, state_d;

  logic                          held_vld_q, held_vld_d;
  logic [TW-1:0]                 held_time_q, held_time_d;
  logic                          held_on_q, held_on_d;
  logic [ntr_pkg::NOTE_W-1:0]    held_note_q, held_note_d;
  logic [TW-1:0]                 start_q, start_d;
  logic [TW-1:0]                 end_q, end_d;

  logic [TW-1:0]                 a_q, a_d;
  logic [TW-1:0]                 b_q, b_d;
  logic [ntr_pkg::BYTE_W-1:0]    code_q, code_d;
  logic                          term_q, term_d;
  logic                          clip_q, clip_d;

  ntr_pkg::rec_t                 rec_q, rec_d;
  logic                          rec_vld_q, rec_vld_d;

  logic [TW-1:0]                 sub_a, sub_b, sub_diff;
  logic                          sub_borrow;
  logic [TW-1:0]                 lim;
  logic [TW-1:0]                 pre_shift;
  logic                          out_free;
  logic                          accept;
  logic                          merge;

  ntr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ntr_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign lim       = TW'(ntr_pkg::MAX_CHUNKS) * TW'(cfg.chunk);
  assign pre_shift = a_q >> (cfg.shift - 3'd1);
  assign out_free  = !rec_vld_q || rec.ready;
  assign evt.ready = (state_q == ntr_pkg::ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign merge     = held_vld_q && (held_time_q == evt.event_time) &&
                     (held_on_q == evt.is_note_on);

  assign rec.valid       = rec_vld_q;
  assign rec.tone_code   = rec_q.tone_code;
  assign rec.tone_length = rec_q.tone_length;
  assign rec.last_record = rec_q.last_record;
  assign rec.clipped     = rec_q.clipped;

  always_comb begin
    case (state_q)
      ntr_pkg::ST_CLIP: begin
        sub_a = lim;
        sub_b = a_q;
      end
      ntr_pkg::ST_EMIT: begin
        sub_a = a_q;
        sub_b = {{(TW-ntr_pkg::BYTE_W){1'b0}}, cfg.chunk};
      end
      default: begin
        sub_a = a_q;
        sub_b = b_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    held_vld_d  = held_vld_q;
    held_time_d = held_time_q;
    held_on_d   = held_on_q;
    held_note_d = held_note_q;
    start_d     = start_q;
    end_d       = end_q;
    a_d         = a_q;
    b_d         = b_q;
    code_d      = code_q;
    term_d      = term_q;
    clip_d      = clip_q;
    rec_d       = rec_q;
    rec_vld_d   = rec_vld_q && !rec.ready;

    case (state_q)
      ntr_pkg::ST_IDLE: begin
        if (accept) begin
          if (!evt.cmd && merge) begin
            if (evt.note_number < held_note_q) begin
              held_note_d = evt.note_number;
            end
          end else begin
            term_d = evt.cmd;
            a_d    = held_time_q;
            if (held_on_q) begin
              b_d     = end_q;
              code_d  = ntr_pkg::REST_CODE;
              start_d = held_time_q;
            end else begin
              b_d    = start_q;
              code_d = {1'b0, held_note_q};
              end_d  = held_time_q;
            end
            if (held_vld_q) begin
              state_d = ntr_pkg::ST_DIFF;
            end else if (evt.cmd) begin
              state_d = ntr_pkg::ST_TERM;
            end
            if (evt.cmd) begin
              held_vld_d  = 1'b0;
              held_time_d = '0;
              held_on_d   = 1'b0;
              held_note_d = '0;
              start_d     = '0;
              end_d       = '0;
            end else begin
              held_vld_d  = 1'b1;
              held_time_d = evt.event_time;
              held_on_d   = evt.is_note_on;
              held_note_d = evt.note_number;
            end
          end
        end
      end
      ntr_pkg::ST_DIFF: begin
        a_d     = sub_borrow ? '0 : sub_diff;
        state_d = ntr_pkg::ST_SCALE;
      end
      ntr_pkg::ST_SCALE: begin
        if (cfg.shift != '0) begin
          a_d = (pre_shift >> 1) + {{(TW-1){1'b0}}, pre_shift[0]};
        end
        state_d = ntr_pkg::ST_CLIP;
      end
      ntr_pkg::ST_CLIP: begin
        // borrow: units exceed MAX_CHUNKS full chunks
        clip_d = sub_borrow;
        if (sub_borrow) begin
          a_d = lim;
        end
        state_d = ntr_pkg::ST_EMIT;
      end
      ntr_pkg::ST_EMIT: begin
        if (out_free) begin
          if (!sub_borrow) begin
            rec_vld_d         = 1'b1;
            rec_d.tone_code   = code_q;
            rec_d.tone_length = cfg.chunk;
            rec_d.last_record = (sub_diff == '0) && !term_q;
            rec_d.clipped     = clip_q;
            a_d               = sub_diff;
          end else begin
            if (a_q != '0) begin
              rec_vld_d         = 1'b1;
              rec_d.tone_code   = code_q;
              rec_d.tone_length = a_q[ntr_pkg::BYTE_W-1:0];
              rec_d.last_record = !term_q;
              rec_d.clipped     = clip_q;
            end
            state_d = term_q ? ntr_pkg::ST_TERM : ntr_pkg::ST_IDLE;
          end
        end
      end
      ntr_pkg::ST_TERM: begin
        if (out_free) begin
          rec_vld_d         = 1'b1;
          rec_d.tone_code   = ntr_pkg::END_CODE;
          rec_d.tone_length = ntr_pkg::END_LENGTH;
          rec_d.last_record = 1'b1;
          rec_d.clipped     = 1'b0;
          state_d           = ntr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ntr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntr_pkg::ST_IDLE;
      held_vld_q  <= 1'b0;
      held_time_q <= '0;
      held_on_q   <= 1'b0;
      held_note_q <= '0;
      start_q     <= '0;
      end_q       <= '0;
      term_q      <= 1'b0;
      clip_q      <= 1'b0;
      rec_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_vld_q  <= held_vld_d;
      held_time_q <= held_time_d;
      held_on_q   <= held_on_d;
      held_note_q <= held_note_d;
      start_q     <= start_d;
      end_q       <= end_d;
      term_q      <= term_d;
      clip_q      <= clip_d;
      rec_vld_q   <= rec_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    code_q <= code_d;
    rec_q  <= rec_d;
  end

  // busy sequencer never takes a beat
  a_busy_no_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ntr_pkg::ST_IDLE) |-> !evt.ready)
    else $error("evt ready while sequencer busy");

  // remaining duration is bounded by the clip limit while peeling chunks
  a_emit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntr_pkg::ST_EMIT) |-> (a_q[TW-1:ntr_pkg::LIM_W] == '0))
    else $error("chunk remainder above limit");

  // clipped records always carry a full chunk
  a_clip_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_vld_q && rec_q.clipped) |-> (rec_q.tone_length == cfg.chunk))
    else $error("clipped record shorter than chunk");

  // terminator is the last beat of its item and never clipped
  a_term_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntr_pkg::ST_TERM && out_free) |=>
      (rec_vld_q && rec_q.last_record && !rec_q.clipped))
    else $error("terminator not marked last");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the note event to tone record converter. Events are
// sent as directed chords, releases, clipping and rounding cases, then as
// random phrases under several register settings. A scoreboard works out the
// expected tone records per accepted event and checks every output beat.
// ----------------------------------------------------------------------------
module tb_top;

  localparam bit          CMD_NOTE      = 1'b0;
  localparam bit          CMD_END       = 1'b1;
  localparam bit          NOTE_ON       = 1'b1;
  localparam bit          NOTE_OFF      = 1'b0;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 200000;

  class tone_scoreboard;
    ntr_pkg::cfg_t                  cfg;
    bit                             held_valid;
    logic [ntr_pkg::TIME_BITS-1:0]  held_time;
    bit                             held_on;
    logic [ntr_pkg::NOTE_W-1:0]     held_note;
    logic [ntr_pkg::TIME_BITS-1:0]  last_start;
    logic [ntr_pkg::TIME_BITS-1:0]  last_end;
    ntr_pkg::rec_t                  due_records[$];
    int unsigned                    errors;

    function new();
      cfg.chunk = ntr_pkg::CHUNK_RESET;
      cfg.shift = ntr_pkg::SHIFT_RESET;
      errors    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      held_valid = 1'b0;
      held_time  = '0;
      held_on    = 1'b0;
      held_note  = '0;
      last_start = '0;
      last_end   = '0;
    endfunction

    function void set_reg(logic [ntr_pkg::CFG_IDX_W-1:0] idx,
                          logic [ntr_pkg::BYTE_W-1:0] data);
      if (idx == ntr_pkg::CFG_MAX_CHUNK) cfg.chunk = data;
      else if (idx == ntr_pkg::CFG_TIME_SHIFT) cfg.shift = data[ntr_pkg::SHIFT_W-1:0];
    endfunction

    function void push_record(logic [ntr_pkg::BYTE_W-1:0] code,
                              logic [ntr_pkg::BYTE_W-1:0] len, bit clip);
      ntr_pkg::rec_t r;
      r.tone_code   = code;
      r.tone_length = len;
      r.last_record = 1'b0;
      r.clipped     = clip;
      due_records.push_back(r);
    endfunction

    // rounded half up: floor((ticks + 2^(s-1)) / 2^s)
    function longint unsigned units_between(logic [ntr_pkg::TIME_BITS-1:0] later,
                                            logic [ntr_pkg::TIME_BITS-1:0] earlier);
      longint unsigned ticks;
      int unsigned     s;
      s     = cfg.shift;
      ticks = (later > earlier) ? (later - earlier) : 0;
      if (s == 0) return ticks;
      return (ticks >> s) + ((ticks >> (s - 1)) & 1);
    endfunction

    function void push_duration(logic [ntr_pkg::BYTE_W-1:0] code, longint unsigned units);
      longint unsigned m, full, rem;
      m = cfg.chunk;
      if (m == 0) m = 1;
      else if (m > ntr_pkg::CHUNK_TOP) m = ntr_pkg::CHUNK_TOP;
      if (units == 0) return;
      full = units / m;
      rem  = units % m;
      if (full > ntr_pkg::MAX_CHUNKS || (full == ntr_pkg::MAX_CHUNKS && rem != 0)) begin
        repeat (ntr_pkg::MAX_CHUNKS) push_record(code, m[ntr_pkg::BYTE_W-1:0], 1'b1);
        return;
      end
      repeat (full) push_record(code, m[ntr_pkg::BYTE_W-1:0], 1'b0);
      if (rem != 0) push_record(code, rem[ntr_pkg::BYTE_W-1:0], 1'b0);
    endfunction

    function void flush_held();
      if (!held_valid) return;
      if (held_on) begin
        last_start = held_time;
        push_duration(ntr_pkg::REST_CODE, units_between(held_time, last_end));
      end else begin
        last_end = held_time;
        push_duration({1'b0, held_note}, units_between(held_time, last_start));
      end
      held_valid = 1'b0;
    endfunction

    function void note_event(bit cmd, logic [ntr_pkg::TIME_BITS-1:0] t, bit on,
                             logic [ntr_pkg::NOTE_W-1:0] note);
      int unsigned   first;
      ntr_pkg::rec_t tail;
      first = due_records.size();
      if (cmd == CMD_END) begin
        flush_held();
        push_record(ntr_pkg::END_CODE, ntr_pkg::END_LENGTH, 1'b0);
        clear_stream();
      end else if (held_valid && held_time == t && held_on == on) begin
        if (note < held_note) held_note = note;
      end else begin
        flush_held();
        held_valid = 1'b1;
        held_time  = t;
        held_on    = on;
        held_note  = note;
      end
      if (due_records.size() > first) begin
        tail = due_records.pop_back();
        tail.last_record = 1'b1;
        due_records.push_back(tail);
      end
    endfunction

    function void field_check(string name, int unsigned want,
                              logic [ntr_pkg::BYTE_W-1:0] got);
      if (got !== want[ntr_pkg::BYTE_W-1:0]) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_record(ntr_pkg::rec_t got);
      ntr_pkg::rec_t want;
      if (due_records.size() == 0) begin
        errors++;
        $display("%0t: stray record, expected none, actual code %0d length %0d",
                 $time, got.tone_code, got.tone_length);
        return;
      end
      want = due_records.pop_front();
      field_check("tone_code", want.tone_code, got.tone_code);
      field_check("tone_length", want.tone_length, got.tone_length);
      field_check("last_record", want.last_record, {7'd0, got.last_record});
      field_check("clipped", want.clipped, {7'd0, got.clipped});
    endfunction

    function int unsigned pending();
      return due_records.size();
    endfunction

    function void report_leftover();
      ntr_pkg::rec_t r;
      while (due_records.size() != 0) begin
        r = due_records.pop_front();
        errors++;
        $display("%0t: missing record, expected code %0d length %0d, actual none",
                 $time, r.tone_code, r.tone_length);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ntr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ntr_pkg::BYTE_W-1:0]    cfg_data_i;
  bit                            quiet_end = 1'b0;

  ntr_evt_if evt_if ();
  ntr_rec_if rec_if ();

  tone_scoreboard board = new();

  note_event_to_tone_records dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt        (evt_if.sink),
    .rec        (rec_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // record sink: ready in random runs, broken by stall bursts of random length
  initial begin
    int unsigned run_left;
    bit          stalled;
    run_left = 0;
    stalled  = 1'b0;
    rec_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (run_left == 0) begin
        if (!quiet_end && $urandom_range(0, 3) == 0) begin
          stalled  = 1'b1;
          run_left = $urandom_range(1, 12);
        end else begin
          stalled  = 1'b0;
          run_left = $urandom_range(1, 30);
        end
      end
      run_left--;
      rec_if.ready <= !stalled;
    end
  end

  always @(posedge clk_i) begin
    ntr_pkg::rec_t got;
    if (rst_ni) begin
      if (cfg_we_i) board.set_reg(cfg_idx_i, cfg_data_i);
      if (evt_if.valid && evt_if.ready)
        board.note_event(evt_if.cmd, evt_if.event_time, evt_if.is_note_on,
                         evt_if.note_number);
      if (rec_if.valid && rec_if.ready) begin
        got.tone_code   = rec_if.tone_code;
        got.tone_length = rec_if.tone_length;
        got.last_record = rec_if.last_record;
        got.clipped     = rec_if.clipped;
        board.check_record(got);
      end
    end
  end

  task automatic send_event(bit cmd, logic [ntr_pkg::TIME_BITS-1:0] t, bit on,
                            logic [ntr_pkg::NOTE_W-1:0] note);
    if (!quiet_end && $urandom_range(0, 4) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    evt_if.valid       <= 1'b1;
    evt_if.cmd         <= cmd;
    evt_if.event_time  <= t;
    evt_if.is_note_on  <= on;
    evt_if.note_number <= note;
    do @(posedge clk_i); while (evt_if.ready !== 1'b1);
  endtask

  // hold off until every expected beat is out or the drain guard trips, then let the sequencer settle
  task automatic settle();
    int unsigned guard;
    guard = 0;
    evt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ntr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ntr_pkg::BYTE_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // span = ticks in one full-length record under the current setting
  function automatic logic [ntr_pkg::TIME_BITS-1:0] pick_ticks(int unsigned m,
                                                              int unsigned s);
    int unsigned span;
    span = m << s;
    case ($urandom_range(0, 11))
      0:             return '0;
      1, 2, 3, 4, 5: return $urandom_range(1, span * 3);
      6, 7, 8:       return $urandom_range(1, span * 40);
      9:             return 63 * span - (1 << s) + $urandom_range(0, 2 << s);
      10:            return $urandom_range(0, 2 << s);
      default:       return $urandom;
    endcase
  endfunction

  task automatic random_stream(int unsigned n_items, int unsigned m, int unsigned s);
    logic [ntr_pkg::TIME_BITS-1:0] now;
    int unsigned                   sent, voices, k;
    now  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        voices = $urandom_range(1, 3);
        now += pick_ticks(m, s);
        for (k = 0; k < voices; k++)
          send_event(CMD_NOTE, now, NOTE_ON, 7'($urandom_range(0, 127)));
        now += pick_ticks(m, s);
        for (k = 0; k < voices; k++)
          send_event(CMD_NOTE, now, NOTE_OFF, 7'($urandom_range(0, 127)));
        sent += 2 * voices;
      end else begin
        case ($urandom_range(0, 4))
          0:       ;
          1:       now -= $urandom_range(1, 500);
          2:       now = $urandom;
          3:       now += pick_ticks(m, s);
          default: now = now;
        endcase
        if ($urandom_range(0, 9) == 0)
          send_event(CMD_END, $urandom, 1'($urandom_range(0, 1)),
                     7'($urandom_range(0, 127)));
        else
          send_event(CMD_NOTE, now, 1'($urandom_range(0, 1)),
                     7'($urandom_range(0, 127)));
        sent++;
      end
      if ($urandom_range(0, 19) == 0) settle();
    end
    send_event(CMD_END, $urandom, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
  endtask

  task automatic run_phase(logic [ntr_pkg::BYTE_W-1:0] chunk_val,
                           logic [ntr_pkg::SHIFT_W-1:0] shift_val,
                           int unsigned n_items);
    logic [ntr_pkg::BYTE_W-1:0] shift_data;
    int unsigned                m;
    shift_data = 8'($urandom);
    shift_data[ntr_pkg::SHIFT_W-1:0] = shift_val;
    settle();
    write_reg(ntr_pkg::CFG_MAX_CHUNK, chunk_val);
    write_reg(ntr_pkg::CFG_TIME_SHIFT, shift_data);
    m = (chunk_val == 0) ? 1 :
        ((chunk_val > ntr_pkg::CHUNK_TOP) ? ntr_pkg::CHUNK_TOP : chunk_val);
    random_stream(n_items, m, shift_val);
  endtask

  initial begin
    evt_if.valid       = 1'b0;
    evt_if.cmd         = CMD_NOTE;
    evt_if.event_time  = '0;
    evt_if.is_note_on  = NOTE_OFF;
    evt_if.note_number = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = ntr_pkg::CFG_MAX_CHUNK;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: empty stream, chord merge, zero rest, half-up rounding,
    // time running backwards, then a huge note that clips at end of stream
    send_event(CMD_END, 32'd0, NOTE_OFF, 7'd0);
    send_event(CMD_NOTE, 32'd0, NOTE_ON, 7'd60);
    send_event(CMD_NOTE, 32'd0, NOTE_ON, 7'd40);
    send_event(CMD_NOTE, 32'd0, NOTE_ON, 7'd50);
    send_event(CMD_NOTE, 32'd100, NOTE_OFF, 7'd40);
    send_event(CMD_NOTE, 32'd100, NOTE_OFF, 7'd70);
    send_event(CMD_NOTE, 32'd50, NOTE_ON, 7'd12);
    send_event(CMD_NOTE, 32'hFFFF_FFFF, NOTE_OFF, 7'd127);
    send_event(CMD_END, 32'hFFFF_FFFF, NOTE_ON, 7'd5);

    // chunk 0 behaves as 1, no scaling
    settle();
    write_reg(ntr_pkg::CFG_MAX_CHUNK, 8'd0);
    write_reg(ntr_pkg::CFG_TIME_SHIFT, 8'd0);
    send_event(CMD_NOTE, 32'd10, NOTE_ON, 7'd0);
    send_event(CMD_NOTE, 32'd15, NOTE_OFF, 7'd0);
    send_event(CMD_END, 32'd0, NOTE_OFF, 7'd0);

    // chunk 255 behaves as 253, widest shift: rounding edge, exact 63 chunks,
    // one unit over the chunk limit
    settle();
    write_reg(ntr_pkg::CFG_MAX_CHUNK, 8'd255);
    write_reg(ntr_pkg::CFG_TIME_SHIFT, 8'hF8 | 8'd7);
    send_event(CMD_NOTE, 32'd63, NOTE_ON, 7'd1);
    send_event(CMD_NOTE, 32'd127, NOTE_OFF, 7'd1);
    send_event(CMD_NOTE, 32'd127 + 32'(63 * 253 * 128), NOTE_ON, 7'd2);
    send_event(CMD_NOTE, 32'd127 + 32'(2 * 63 * 253 * 128) + 32'd64, NOTE_OFF, 7'd3);
    send_event(CMD_END, 32'h8000_0000, NOTE_ON, 7'd127);

    run_phase(ntr_pkg::CHUNK_RESET, ntr_pkg::SHIFT_RESET, 14);
    run_phase(8'd1, 3'd0, 14);
    run_phase(8'd254, 3'd7, 14);
    run_phase(ntr_pkg::CHUNK_TOP, 3'd1, 14);
    run_phase(8'($urandom_range(1, 253)), 3'($urandom_range(0, 7)), 14);
    run_phase(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 14);
    settle();
    quiet_end = 1'b1;
    run_phase(8'($urandom_range(1, 253)), 3'($urandom_range(0, 7)), 14);

    settle();
    repeat (20) @(posedge clk_i);
    board.report_leftover();
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ntr_pkg.sv
sv/ntr_if.sv
sv/ntr_sub.sv
sv/ntr_cfg.sv
sv/note_event_to_tone_records.sv
dv/tb_top.sv
